>>> rtl/core/complementary_attitude_filter_top_defines.svh
// Assertion macros for the attitude filter.
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_TOP_DEFINES_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_TOP_DEFINES_SVH
`ifndef SYNTH
`define CAF_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define CAF_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define CAF_ASSERT_IMPL(label, a, c)
`define CAF_ASSERT_NEXT(label, a, c)
`endif
`endif

>>> rtl/core/caf_pkg.sv
package caf_pkg;
	localparam logic [1:0] REG_ROLL_BIAS = 2'd0;
	localparam logic [1:0] REG_PITCH_BIAS = 2'd1;
	localparam logic [1:0] REG_BLEND = 2'd2;
	localparam logic [9:0] BLEND_RESET = 10'd600;
	localparam int OctAngle = 450;
	localparam int RightAngle = 900;
	localparam int HalfTurn = 1800;
	localparam int RateMul = 10;
	localparam int RateDiv = 6553;
	// Widths of the serial divider: 40-bit dividend, 17-bit divisor.
	localparam int NumW = 40;
	localparam int DenW = 17;
	localparam int CntW = 6;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SMOOTH = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_POST  = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		OP_ATAN_R  = 3'd0,
		OP_ATAN_P  = 3'd1,
		OP_RATE_R  = 3'd2,
		OP_RATE_P  = 3'd3,
		OP_BLEND_R = 3'd4,
		OP_BLEND_P = 3'd5
	} op_t;
endpackage

>>> rtl/core/complementary_attitude_filter_top.sv
// Channel   Handshake               Payload
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
// in        in_valid / in_ready     accel_x..z, rate_x/y_first, rate_x/y_second
// out       out_valid / out_ready   roll_angle, pitch_angle
// An item takes six restoring divisions of one quotient bit per cycle, run on
// one shared divider; no new input is taken until the result of the last one
// has been taken at the output.
// Reset loads the bias registers with zero, the blend weight with 600 and
// clears the smoothed samples and angles. A stalled result holds in the output
// register; in_ready stays low until it is taken and while a configuration
// write is offered.
module complementary_attitude_filter_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x_first,
	input  logic signed [15:0] rate_y_first,
	input  logic signed [15:0] rate_x_second,
	input  logic signed [15:0] rate_y_second,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle
);
	import caf_pkg::*;
`include "complementary_attitude_filter_top_defines.svh"

	state_t state_q;
	op_t op_q;
	logic signed [15:0] roll_bias_q, pitch_bias_q;
	logic [9:0] blend_q;
	logic signed [15:0] sacc_q [3];
	logic signed [15:0] ang_q [2];
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [16:0] rroll_q, rpitch_q;
	logic signed [15:0] acc_roll_q, acc_pitch_q;
	logic signed [16:0] dl_roll_q, dl_pitch_q;

	logic [NumW-1:0] rem_q;   // shift register: partial remainder; the quotient shifts into quo_q
	logic [NumW-1:0] quo_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic neg_q;
	logic [1:0] fix_q;        // atan fixup: bit0 swapped octant, bit1 x negative
	logic yneg_q;

	logic signed [17:0] sum_x, sum_y;
	logic signed [16:0] avg_x, avg_y;
	logic signed [17:0] sm_n [3];
	logic [16:0] aby, abx;
	logic [16:0] trial;
	logic [NumW:0] rem_sh;

	assign cfg_ready = state_q == ST_IDLE;
	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign sum_x = 18'(rate_x_first) + 18'(rate_x_second);
	assign sum_y = 18'(rate_y_first) + 18'(rate_y_second);
	assign avg_x = 17'(sum_x >>> 1) - 17'(roll_bias_q);
	assign avg_y = 17'(sum_y >>> 1) - 17'(pitch_bias_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sm_n[i] = 18'(sacc_q[i]) + (18'(sacc_q[i]) <<< 1);
		end
		sm_n[0] = sm_n[0] + 18'(ax_q);
		sm_n[1] = sm_n[1] + 18'(ay_q);
		sm_n[2] = sm_n[2] + 18'(az_q);
	end

	logic signed [15:0] aty;
	always_comb begin
		aty = (op_q == OP_ATAN_R) ? sacc_q[1] : sacc_q[0];
		aby = aty[15] ? 17'(-18'(aty)) : 17'(aty);
		abx = sacc_q[2][15] ? 17'(-18'(sacc_q[2])) : 17'(sacc_q[2]);
	end

	assign rem_sh = {rem_q, quo_q[NumW-1]};
	assign trial = rem_sh[DenW-1:0];

	logic [DenW:0] diff;
	always_comb begin
		diff = {1'b0, rem_sh[DenW-1:0]} - {1'b0, den_q};
	end

	// Loading of a division: magnitude dividend, divisor, sign of the quotient.
	logic [NumW-1:0] ld_num;
	logic [DenW-1:0] ld_den;
	logic ld_neg;
	logic [1:0] ld_fix;
	logic ld_yneg;
	logic signed [NumW:0] bnum;
	logic signed [16:0] ang_sel, dl_sel, acc_sel;
	always_comb begin
		ld_num = '0;
		ld_den = 17'd1;
		ld_neg = 1'b0;
		ld_fix = 2'b00;
		ld_yneg = aty[15];
		ang_sel = (op_q == OP_BLEND_R) ? 17'(ang_q[0]) : 17'(ang_q[1]);
		dl_sel = (op_q == OP_BLEND_R) ? dl_roll_q : dl_pitch_q;
		acc_sel = (op_q == OP_BLEND_R) ? 17'(acc_roll_q) : 17'(acc_pitch_q);
		bnum = 41'(signed'({1'b0, blend_q})) * 41'(18'(ang_sel) + 18'(dl_sel)) + 41'(acc_sel);
		case (op_q)
			OP_ATAN_R, OP_ATAN_P: begin
				ld_fix[1] = sacc_q[2][15];
				if (abx >= aby) begin
					ld_num = NumW'(aby) * NumW'(OctAngle);
					ld_den = (abx == 17'd0) ? 17'd1 : abx;
				end else begin
					ld_num = NumW'(abx) * NumW'(OctAngle);
					ld_den = aby;
					ld_fix[0] = 1'b1;
				end
			end
			OP_RATE_R, OP_RATE_P: begin
				dl_sel = (op_q == OP_RATE_R) ? rroll_q : rpitch_q;
				ld_neg = dl_sel[16];
				ld_num = NumW'(dl_sel[16] ? 18'(-18'(dl_sel)) : 18'(dl_sel)) * NumW'(RateMul);
				ld_den = DenW'(RateDiv);
			end
			OP_BLEND_R, OP_BLEND_P: begin
				ld_neg = bnum[NumW];
				ld_num = bnum[NumW] ? NumW'(-bnum) : NumW'(bnum);
				ld_den = DenW'({1'b0, blend_q} + 11'd1);
			end
			default: begin
				ld_num = '0;
			end
		endcase
	end

	logic signed [NumW:0] qs;
	logic signed [15:0] atan_v;
	always_comb begin
		qs = neg_q ? -(NumW+1)'(quo_q) : (NumW+1)'(quo_q);
		atan_v = 16'(quo_q);
		if (fix_q[0]) atan_v = 16'(RightAngle) - atan_v;
		if (fix_q[1]) atan_v = 16'(HalfTurn) - atan_v;
		if (yneg_q) atan_v = -atan_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_ATAN_R;
			roll_bias_q <= '0;
			pitch_bias_q <= '0;
			blend_q <= BLEND_RESET;
			for (int i = 0; i < 3; i++) sacc_q[i] <= '0;
			ang_q[0] <= '0;
			ang_q[1] <= '0;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_ROLL_BIAS: roll_bias_q <= cfg_data;
							REG_PITCH_BIAS: pitch_bias_q <= cfg_data;
							REG_BLEND: blend_q <= cfg_data[9:0];
							default: ;
						endcase
					end
					if (in_valid && in_ready) begin
						ax_q <= accel_x;
						ay_q <= accel_y;
						az_q <= accel_z;
						rroll_q <= avg_x;
						rpitch_q <= avg_y;
						state_q <= ST_SMOOTH;
					end
				end
				ST_SMOOTH: begin
					for (int i = 0; i < 3; i++) sacc_q[i] <= 16'(sm_n[i] >>> 2);
					op_q <= OP_ATAN_R;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rem_q <= '0;
					quo_q <= ld_num;
					den_q <= ld_den;
					neg_q <= ld_neg;
					fix_q <= ld_fix;
					yneg_q <= ld_yneg;
					cnt_q <= CntW'(NumW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!diff[DenW]) begin
						rem_q <= NumW'(diff[DenW-1:0]);
						quo_q <= {quo_q[NumW-2:0], 1'b1};
					end else begin
						rem_q <= NumW'(trial);
						quo_q <= {quo_q[NumW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == CntW'(1)) state_q <= ST_POST;
				end
				ST_POST: begin
					state_q <= ST_LOAD;
					case (op_q)
						OP_ATAN_R: begin
							acc_roll_q <= (abx == 17'd0 && aby == 17'd0) ? '0 : atan_v;
							op_q <= OP_ATAN_P;
						end
						OP_ATAN_P: begin
							acc_pitch_q <= (abx == 17'd0 && aby == 17'd0) ? '0 : atan_v;
							op_q <= OP_RATE_R;
						end
						OP_RATE_R: begin
							dl_roll_q <= 17'(qs);
							op_q <= OP_RATE_P;
						end
						OP_RATE_P: begin
							dl_pitch_q <= 17'(qs);
							op_q <= OP_BLEND_R;
						end
						OP_BLEND_R: begin
							ang_q[0] <= 16'(qs);
							op_q <= OP_BLEND_P;
						end
						default: begin
							ang_q[1] <= 16'(qs);
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign roll_angle = ang_q[0];
	assign pitch_angle = ang_q[1];

	`CAF_ASSERT_IMPL(a_out_only_in_out, out_valid, state_q == ST_OUT)
	`CAF_ASSERT_NEXT(a_take_starts, in_valid && in_ready, state_q == ST_SMOOTH)
	`CAF_ASSERT_IMPL(a_div_count, state_q == ST_DIV, cnt_q != '0)
endmodule
